@@ rtl/pfsu_pkg.sv @@
package pfsu_pkg;

	// Event codes carried in s_tuser.
	localparam logic [1:0] ACT_WRITE     = 2'd0;
	localparam logic [1:0] ACT_TRIGGER   = 2'd1;
	localparam logic [1:0] ACT_TICK      = 2'd2;
	localparam logic [1:0] ACT_POWER_OFF = 2'd3;

	localparam int ACTION_BITS  = 2;
	localparam int VALUE_BITS   = 8;
	localparam int CHAN_BITS    = 11;
	localparam int PERIOD_BITS  = 3;
	localparam int SHIFT_BITS   = 3;
	localparam int TIMER_BITS   = 4;
	localparam int IN_DATA_BITS  = 24;
	localparam int OUT_DATA_BITS = 16;

	// A period of zero reloads the timer with eight.
	localparam logic [TIMER_BITS-1:0] RELOAD_ZERO = 4'd8;

	localparam int DEF_FREQ_BITS = 11;

endpackage

@@ rtl/pfsu_calc.sv @@
module pfsu_calc #(
	parameter int FREQ_BITS = 11
) (
	input  logic [FREQ_BITS-1:0]          shadow,
	input  logic [pfsu_pkg::SHIFT_BITS-1:0] shift,
	input  logic                          decrease,
	output logic [FREQ_BITS-1:0]          next_freq,
	output logic                          overflow
);
	import pfsu_pkg::*;

	logic [FREQ_BITS-1:0] offset;
	logic [FREQ_BITS:0]   sum;
	logic [FREQ_BITS-1:0] diff;

	assign offset = shadow >> shift;
	assign sum    = {1'b0, shadow} + {1'b0, offset};
	// The offset never exceeds the shadow, so the difference cannot wrap.
	assign diff   = shadow - offset;

	assign overflow  = !decrease && sum[FREQ_BITS];
	assign next_freq = decrease ? diff : sum[FREQ_BITS-1:0];

endmodule

@@ rtl/pulse_frequency_sweep_unit.sv @@
// Frequency sweep for a pulse sound channel.
// Input words arrive on the s_ stream: s_tuser holds the event (register write,
// trigger, sweep tick, power off), s_tdata the sweep register byte and the
// current channel frequency. Every input word yields exactly one output word on
// the m_ stream: a disable flag, a frequency-update flag and the new frequency.
// An accepted word is held in an input register, then the event is evaluated
// against the sweep state and the result lands in the output register, which
// raises m_tvalid. Both shift-add checks of a tick are done combinationally,
// so one word is taken every cycle while the output is drained.
// When the receiver stalls, the result holds in the output register and one
// further word may wait in the input register; s_tready drops only when both
// are full. Reset clears all sweep state and both valid flags; the power-off
// event does the same for the sweep state in band.
module pulse_frequency_sweep_unit #(
	parameter int FREQ_BITS = pfsu_pkg::DEF_FREQ_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [1:0] action
	input  logic [pfsu_pkg::ACTION_BITS-1:0]   s_tuser,
	// [7:0] reg_value, [18:8] channel_frequency, upper bits zero
	input  logic [pfsu_pkg::IN_DATA_BITS-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] disable_channel, [1] freq_update, [12:2] new_frequency, upper bits zero
	output logic [pfsu_pkg::OUT_DATA_BITS-1:0] m_tdata
);
	import pfsu_pkg::*;

	logic                   valid_s1;
	logic [ACTION_BITS-1:0] action_s1;
	logic [VALUE_BITS-1:0]  value_s1;
	logic [CHAN_BITS-1:0]   chan_s1;
	logic                   adv_s1;

	logic [PERIOD_BITS-1:0] period_q, period_d;
	logic                   decrease_q, decrease_d;
	logic [SHIFT_BITS-1:0]  shift_q, shift_d;
	logic [FREQ_BITS-1:0]   shadow_q, shadow_d;
	logic [TIMER_BITS-1:0]  timer_q, timer_d;
	logic                   enabled_q, enabled_d;
	logic                   latch_q, latch_d;

	logic [31:0]            chan_wide;
	logic [FREQ_BITS-1:0]   chan_fb;
	logic [TIMER_BITS-1:0]  reload;
	logic [TIMER_BITS-1:0]  timer_dec;
	logic [FREQ_BITS-1:0]   calc_in_a, next_a, next_b;
	logic                   ovf_a, ovf_b;
	logic                   dis, upd;
	logic [FREQ_BITS-1:0]   nf;
	logic [31:0]            nf_wide;

	assign adv_s1   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			value_s1  <= s_tdata[VALUE_BITS-1:0];
			chan_s1   <= s_tdata[VALUE_BITS+CHAN_BITS-1:VALUE_BITS];
		end
	end

	// The channel frequency is masked to the shadow width.
	assign chan_wide = 32'(chan_s1);
	assign chan_fb   = chan_wide[FREQ_BITS-1:0];

	assign reload    = (period_q == '0) ? RELOAD_ZERO : TIMER_BITS'(period_q);
	assign timer_dec = (timer_q != '0) ? timer_q - 1'b1 : '0;

	assign calc_in_a = (action_s1 == ACT_TRIGGER) ? chan_fb : shadow_q;

	pfsu_calc #(.FREQ_BITS(FREQ_BITS)) u_calc_a (
		.shadow    (calc_in_a),
		.shift     (shift_q),
		.decrease  (decrease_q),
		.next_freq (next_a),
		.overflow  (ovf_a)
	);

	// Second check runs on the value just written back.
	pfsu_calc #(.FREQ_BITS(FREQ_BITS)) u_calc_b (
		.shadow    (next_a),
		.shift     (shift_q),
		.decrease  (decrease_q),
		.next_freq (next_b),
		.overflow  (ovf_b)
	);

	always_comb begin
		period_d   = period_q;
		decrease_d = decrease_q;
		shift_d    = shift_q;
		shadow_d   = shadow_q;
		timer_d    = timer_q;
		enabled_d  = enabled_q;
		latch_d    = latch_q;
		dis        = 1'b0;
		upd        = 1'b0;
		nf         = '0;
		unique case (action_s1)
			ACT_WRITE: begin
				period_d   = value_s1[6:4];
				decrease_d = value_s1[3];
				shift_d    = value_s1[2:0];
				dis        = latch_q && !value_s1[3];
			end
			ACT_TRIGGER: begin
				shadow_d  = chan_fb;
				timer_d   = reload;
				enabled_d = (period_q != '0) || (shift_q != '0);
				latch_d   = 1'b0;
				if (shift_q != '0) begin
					if (decrease_q) begin
						latch_d = 1'b1;
					end
					dis = ovf_a;
				end
			end
			ACT_TICK: begin
				timer_d = timer_dec;
				if (timer_dec == '0) begin
					timer_d = reload;
					if (enabled_q && (period_q != '0)) begin
						if (decrease_q) begin
							latch_d = 1'b1;
						end
						if (ovf_a) begin
							dis = 1'b1;
						end else if (shift_q != '0) begin
							shadow_d = next_a;
							upd      = 1'b1;
							nf       = next_a;
							dis      = ovf_b;
						end
					end
				end
			end
			ACT_POWER_OFF: begin
				period_d   = '0;
				decrease_d = 1'b0;
				shift_d    = '0;
				shadow_d   = '0;
				timer_d    = '0;
				enabled_d  = 1'b0;
				latch_d    = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= '0;
			decrease_q <= 1'b0;
			shift_q    <= '0;
			shadow_q   <= '0;
			timer_q    <= '0;
			enabled_q  <= 1'b0;
			latch_q    <= 1'b0;
		end else if (adv_s1) begin
			period_q   <= period_d;
			decrease_q <= decrease_d;
			shift_q    <= shift_d;
			shadow_q   <= shadow_d;
			timer_q    <= timer_d;
			enabled_q  <= enabled_d;
			latch_q    <= latch_d;
		end
	end

	assign nf_wide = 32'(nf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_tdata <= {3'b000, nf_wide[CHAN_BITS-1:0], upd, dis};
		end
	end

`ifndef SYNTHESIS
	a_no_freq_without_update: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[12:2] == '0)
		else $error("new frequency is non-zero without an update");

	a_timer_range: assert property (@(posedge clk) disable iff (!arst_n)
		timer_q <= RELOAD_ZERO)
		else $error("sweep timer above its largest reload value");

	a_power_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && action_s1 == ACT_POWER_OFF |=>
		shadow_q == '0 && timer_q == '0 && !latch_q && !enabled_q)
		else $error("power off left sweep state behind");

	a_stall_holds_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");
`endif

endmodule
